@@ hw/rtl/ir_ac_frame_decoder_macros.svh @@
// Assertion helpers for the checker of the frame decoder.
`ifndef IR_AC_FRAME_DECODER_MACROS_SVH
`define IR_AC_FRAME_DECODER_MACROS_SVH

// Checked only while out of reset.
`define IRAC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset cycles included.
`define IRAC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/ir_ac_pkg.sv @@
package ir_ac_pkg;

  localparam int unsigned FRAME_BYTES = 18;
  localparam int unsigned BIT_CNT_W   = 8;
  localparam int unsigned BYTE_IDX_W  = BIT_CNT_W - 3;

  localparam int unsigned TOL_W      = 7;
  localparam int unsigned TMIN_W     = 6;
  localparam int unsigned TOL_MAX    = 100;
  localparam int unsigned PCT_SCALE  = 100;
  localparam int unsigned DUR_W      = 16;

  localparam int unsigned HDR_MARK   = 3600;
  localparam int unsigned HDR_SPACE  = 1700;
  localparam int unsigned BIT_MARK   = 460;
  localparam int unsigned ONE_SPACE  = 1260;
  localparam int unsigned ZERO_SPACE = 400;

  // Configuration register indexes
  localparam logic CFG_TOLERANCE = 1'b0;
  localparam logic CFG_TEMP_MIN  = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BIT_ERR = 2'd1;
  localparam logic [1:0] ST_SUM_ERR = 2'd2;

  // Operating mode codes and their raw byte values
  localparam logic [2:0] MODE_OFF  = 3'd0;
  localparam logic [2:0] MODE_HEAT = 3'd1;
  localparam logic [2:0] MODE_COOL = 3'd2;
  localparam logic [2:0] MODE_AUTO = 3'd3;
  localparam logic [2:0] MODE_DRY  = 3'd4;

  localparam logic [7:0] BYTE_HEAT = 8'h08;
  localparam logic [7:0] BYTE_COOL = 8'h18;
  localparam logic [7:0] BYTE_AUTO = 8'h20;
  localparam logic [7:0] BYTE_DRY  = 8'h10;

  typedef struct packed {
    logic [DUR_W-1:0] mark_us;
    logic [DUR_W-1:0] space_us;
  } in_beat_t;

  typedef struct packed {
    logic [1:0] status;
    logic [2:0] mode;
    logic [7:0] mode_byte;
    logic [7:0] temp_code;
    logic [8:0] temperature;
  } out_beat_t;

  // Window matches of one pair against the three pair shapes
  typedef struct packed {
    logic hdr;
    logic one;
    logic zero;
  } pair_match_t;

  typedef logic [DUR_W-1:0] bnd_tbl_t [0:TOL_MAX];

  // Bound table over every tolerance, built at elaboration
  function automatic bnd_tbl_t mk_bnd(int unsigned nom, bit upper);
    bnd_tbl_t    tbl;
    int unsigned p;
    for (int unsigned i = 0; i <= TOL_MAX; i++) begin
      p      = upper ? (PCT_SCALE + i) : (PCT_SCALE - i);
      tbl[i] = DUR_W'((nom * p) / PCT_SCALE);
    end
    return tbl;
  endfunction

  localparam bnd_tbl_t HDR_MARK_LO   = mk_bnd(HDR_MARK, 1'b0);
  localparam bnd_tbl_t HDR_MARK_HI   = mk_bnd(HDR_MARK, 1'b1);
  localparam bnd_tbl_t HDR_SPACE_LO  = mk_bnd(HDR_SPACE, 1'b0);
  localparam bnd_tbl_t HDR_SPACE_HI  = mk_bnd(HDR_SPACE, 1'b1);
  localparam bnd_tbl_t BIT_MARK_LO   = mk_bnd(BIT_MARK, 1'b0);
  localparam bnd_tbl_t BIT_MARK_HI   = mk_bnd(BIT_MARK, 1'b1);
  localparam bnd_tbl_t ONE_SPACE_LO  = mk_bnd(ONE_SPACE, 1'b0);
  localparam bnd_tbl_t ONE_SPACE_HI  = mk_bnd(ONE_SPACE, 1'b1);
  localparam bnd_tbl_t ZERO_SPACE_LO = mk_bnd(ZERO_SPACE, 1'b0);
  localparam bnd_tbl_t ZERO_SPACE_HI = mk_bnd(ZERO_SPACE, 1'b1);

endpackage

@@ hw/rtl/ir_ac_in_reg.sv @@
module ir_ac_in_reg
  import ir_ac_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_beat_t in_data,
  input  logic     adv,
  output logic     s1_valid,
  output in_beat_t s1_data
);

  logic     s1_valid_r, s1_valid_nxt;
  in_beat_t s1_data_r;
  logic     load;

  // Hold the beat while the core cannot take it
  assign in_stall = s1_valid_r && !adv;
  assign load     = in_valid && !in_stall;

  always_comb begin
    if (load) begin
      s1_valid_nxt = 1'b1;
    end else if (adv) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_data_r <= in_data;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_data  = s1_data_r;

endmodule

@@ hw/rtl/ir_ac_win.sv @@
module ir_ac_win
  import ir_ac_pkg::*;
(
  input  logic [TOL_W-1:0] tol,
  input  in_beat_t         pair,
  output pair_match_t      match
);

  logic [TOL_W-1:0] t_idx;
  logic             hdr_m, hdr_s, bit_m, one_s, zero_s;

  // Tolerances above the full scale act as the full scale
  assign t_idx = (tol > TOL_W'(TOL_MAX)) ? TOL_W'(TOL_MAX) : tol;

  assign hdr_m  = (pair.mark_us  >= HDR_MARK_LO[t_idx])   && (pair.mark_us  <= HDR_MARK_HI[t_idx]);
  assign hdr_s  = (pair.space_us >= HDR_SPACE_LO[t_idx])  && (pair.space_us <= HDR_SPACE_HI[t_idx]);
  assign bit_m  = (pair.mark_us  >= BIT_MARK_LO[t_idx])   && (pair.mark_us  <= BIT_MARK_HI[t_idx]);
  assign one_s  = (pair.space_us >= ONE_SPACE_LO[t_idx])  && (pair.space_us <= ONE_SPACE_HI[t_idx]);
  assign zero_s = (pair.space_us >= ZERO_SPACE_LO[t_idx]) && (pair.space_us <= ZERO_SPACE_HI[t_idx]);

  assign match.hdr  = hdr_m && hdr_s;
  assign match.one  = bit_m && one_s;
  assign match.zero = bit_m && zero_s;

endmodule

@@ hw/rtl/ir_ac_core.sv @@
module ir_ac_core
  import ir_ac_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic [TMIN_W-1:0] temp_min,
  input  logic              s1_valid,
  input  pair_match_t       match,
  output logic              adv,
  output logic              out_valid,
  input  logic              out_stall,
  output out_beat_t         out_data
);

  logic                 in_frame_r, in_frame_nxt;
  logic [BIT_CNT_W-1:0] bit_cnt_r, bit_cnt_nxt;
  logic [7:0]           byte_acc_r, byte_acc_nxt;
  logic [7:0]           sum_acc_r, sum_acc_nxt;
  logic [7:0]           mode_r, mode_nxt;
  logic [7:0]           temp_r, temp_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_beat_t            out_data_r, res;

  logic                  fire, emit, bad;
  logic [2:0]            pos;
  logic [BYTE_IDX_W-1:0] idx;
  logic [7:0]            acc_new;

  assign adv  = !out_valid_r || !out_stall;
  assign fire = s1_valid && adv;
  assign bad  = !match.one && !match.zero;
  assign pos  = bit_cnt_r[2:0];
  assign idx  = bit_cnt_r[BIT_CNT_W-1:3];
  // One window wins over zero where they overlap
  assign acc_new = byte_acc_r | (8'(match.one) << pos);

  function automatic logic [2:0] mode_of(logic [7:0] b);
    logic [2:0] m;
    unique case (b)
      BYTE_HEAT: m = MODE_HEAT;
      BYTE_COOL: m = MODE_COOL;
      BYTE_AUTO: m = MODE_AUTO;
      BYTE_DRY:  m = MODE_DRY;
      default:   m = MODE_OFF;
    endcase
    return m;
  endfunction

  always_comb begin
    in_frame_nxt = in_frame_r;
    bit_cnt_nxt  = bit_cnt_r;
    byte_acc_nxt = byte_acc_r;
    sum_acc_nxt  = sum_acc_r;
    mode_nxt     = mode_r;
    temp_nxt     = temp_r;
    emit         = 1'b0;
    res          = '0;
    if (fire) begin
      if (!in_frame_r) begin
        if (match.hdr) begin
          in_frame_nxt = 1'b1;
          bit_cnt_nxt  = '0;
          byte_acc_nxt = '0;
          sum_acc_nxt  = '0;
        end
      end else if (bad) begin
        emit         = 1'b1;
        res.status   = ST_BIT_ERR;
        in_frame_nxt = 1'b0;
        bit_cnt_nxt  = '0;
        byte_acc_nxt = '0;
        sum_acc_nxt  = '0;
      end else if (pos != 3'd7) begin
        byte_acc_nxt = acc_new;
        bit_cnt_nxt  = bit_cnt_r + 1'b1;
      end else if (idx != BYTE_IDX_W'(FRAME_BYTES - 1)) begin
        sum_acc_nxt  = sum_acc_r + acc_new;
        if (idx == BYTE_IDX_W'(6)) begin
          mode_nxt = acc_new;
        end else if (idx == BYTE_IDX_W'(7)) begin
          temp_nxt = acc_new;
        end
        byte_acc_nxt = '0;
        bit_cnt_nxt  = bit_cnt_r + 1'b1;
      end else begin
        // Last byte is the checksum of all before it
        emit = 1'b1;
        if (sum_acc_r == acc_new) begin
          res.status      = ST_OK;
          res.mode        = mode_of(mode_r);
          res.mode_byte   = mode_r;
          res.temp_code   = temp_r;
          res.temperature = {1'b0, temp_r} + {3'b000, temp_min};
        end else begin
          res.status = ST_SUM_ERR;
        end
        in_frame_nxt = 1'b0;
        bit_cnt_nxt  = '0;
        byte_acc_nxt = '0;
        sum_acc_nxt  = '0;
      end
    end
  end

  always_comb begin
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r  <= 1'b0;
      bit_cnt_r   <= '0;
      byte_acc_r  <= '0;
      sum_acc_r   <= '0;
      mode_r      <= '0;
      temp_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      in_frame_r  <= in_frame_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
      byte_acc_r  <= byte_acc_nxt;
      sum_acc_r   <= sum_acc_nxt;
      mode_r      <= mode_nxt;
      temp_r      <= temp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ hw/rtl/ir_ac_frame_decoder.sv @@
// Channel | Dir | Handshake        | Beat payload
// in_     | in  | in_valid/in_stall   | in_beat_t: mark_us, space_us
// out_    | out | out_valid/out_stall | out_beat_t: status, mode, mode_byte,
//         |     |                     |   temp_code, temperature
// cfg_    | in  | cfg_we              | cfg_index, cfg_wdata
//
// One beat per cycle sustained while no result waits on out_stall. A beat
// is held in the input register, then the window compare and frame logic
// load the result register from it once the core advances.
// Reset (rst_n low, synchronous) returns to header hunt and empties both
// registers; tolerance comes back to 25 percent and the minimum to 16.
// A result waiting on out_stall holds; an empty input register still takes
// one more beat behind it before in_stall rises.
module ir_ac_frame_decoder
  import ir_ac_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_beat_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_beat_t        out_data,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [TOL_W-1:0] cfg_wdata
);

  logic [TOL_W-1:0]  tol_r, tol_nxt;
  logic [TMIN_W-1:0] tmin_r, tmin_nxt;

  logic        adv;
  logic        s1_valid;
  in_beat_t    s1_data;
  pair_match_t match;

  // Configuration registers: write only, no read-back
  always_comb begin
    tol_nxt  = tol_r;
    tmin_nxt = tmin_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_TOLERANCE: tol_nxt  = cfg_wdata;
        CFG_TEMP_MIN:  tmin_nxt = cfg_wdata[TMIN_W-1:0];
        default:       tol_nxt  = tol_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r  <= TOL_W'(25);
      tmin_r <= TMIN_W'(16);
    end else begin
      tol_r  <= tol_nxt;
      tmin_r <= tmin_nxt;
    end
  end

  // Input register
  ir_ac_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .adv      (adv),
    .s1_valid (s1_valid),
    .s1_data  (s1_data)
  );

  // Tolerance windows for header, one and zero
  ir_ac_win u_win (
    .tol   (tol_r),
    .pair  (s1_data),
    .match (match)
  );

  // Frame tracking, checksum and result register
  ir_ac_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .temp_min  (tmin_r),
    .s1_valid  (s1_valid),
    .match     (match),
    .adv       (adv),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

@@ hw/rtl/ir_ac_chk.sv @@
`include "ir_ac_frame_decoder_macros.svh"

module ir_ac_chk
  import ir_ac_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_beat_t out_data
);

  logic out_held;
  logic err_beat;
  logic res_data_zero;
  logic status_known;

  assign out_held      = out_valid && out_stall;
  assign err_beat      = out_valid && (out_data.status != ST_OK);
  assign res_data_zero = (out_data.mode == MODE_OFF) && (out_data.mode_byte == 8'h00) &&
                         (out_data.temp_code == 8'h00) && (out_data.temperature == 9'h000);
  assign status_known  = (out_data.status == ST_OK) || (out_data.status == ST_BIT_ERR) ||
                         (out_data.status == ST_SUM_ERR);

  `IRAC_ASSERT_ALWAYS(a_rst_empty, !rst_n |=> !out_valid, "result valid right after reset")
  `IRAC_ASSERT(a_out_hold, out_held |=> out_valid && $stable(out_data), "stalled result changed")
  `IRAC_ASSERT(a_no_stall_idle, !out_valid |-> !in_stall, "input stalled with no result pending")
  `IRAC_ASSERT(a_err_zero, err_beat |-> res_data_zero, "error result carries data")
  `IRAC_ASSERT(a_status_code, out_valid |-> status_known, "bad status code")

endmodule

bind ir_ac_frame_decoder ir_ac_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

@@ tb/tb_ir_ac_frame_decoder.sv @@
module tb_ir_ac_frame_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  import ir_ac_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 6;   // input and result registers plus the skid beat, with margin
  localparam int unsigned FRAME_BITS    = FRAME_BYTES * 8;

  typedef enum int unsigned {
    FRAME_GOOD,
    FRAME_BAD_SUM,
    FRAME_BROKEN
  } frame_kind_t;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  in_beat_t         in_data;
  logic             out_valid;
  logic             out_stall;
  out_beat_t        out_data;
  logic             cfg_we;
  logic             cfg_index;
  logic [TOL_W-1:0] cfg_wdata;

  ir_ac_frame_decoder i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Decoder mirror: register copies and frame state, updated once per accepted beat.
  logic [TOL_W-1:0]  tol_pct;
  logic [TMIN_W-1:0] temp_floor;
  logic              frame_open;
  logic [7:0]        bit_pos;
  logic [7:0]        byte_acc;
  logic [7:0]        sum_acc;
  logic [7:0]        mode_seen;
  logic [7:0]        temp_seen;

  out_beat_t   frame_reports[$];   // decode results still owed by the block
  int unsigned live_items   = 0;   // beats that reached the frame logic (not idle noise)
  int unsigned results_due  = 0;
  int unsigned error_count  = 0;
  int unsigned send_gap_pct   = 19;
  int unsigned recv_stall_pct = 45;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic flag_error(string msg);
    $display("ERROR @%0t: %s", $time, msg);
    error_count++;
  endtask

  // Acceptance window of a nominal duration under the current tolerance.
  function automatic void window_of(int unsigned nom, output int unsigned lo,
                                    output int unsigned hi);
    int unsigned t;
    t  = (tol_pct > TOL_MAX) ? TOL_MAX : tol_pct;
    lo = nom * (PCT_SCALE - t) / PCT_SCALE;
    hi = nom * (PCT_SCALE + t) / PCT_SCALE;
  endfunction

  function automatic bit pair_fits(in_beat_t p, int unsigned nom_mark,
                                   int unsigned nom_space);
    int unsigned mlo, mhi, slo, shi;
    window_of(nom_mark, mlo, mhi);
    window_of(nom_space, slo, shi);
    return (p.mark_us >= mlo) && (p.mark_us <= mhi) &&
           (p.space_us >= slo) && (p.space_us <= shi);
  endfunction

  function automatic void clear_frame();
    frame_open = 1'b0;
    bit_pos    = '0;
    byte_acc   = '0;
    sum_acc    = '0;
  endfunction

  // Advance the mirror by one pair; return 1 when the pair closes out a result.
  function automatic bit decode_pair(in_beat_t p, output out_beat_t r);
    logic       one_bit;
    logic [4:0] idx;
    r = '0;
    if (!frame_open) begin
      // Hunting for a header: drop everything else silently.
      if (pair_fits(p, HDR_MARK, HDR_SPACE)) begin
        clear_frame();
        frame_open = 1'b1;
      end
      return 1'b0;
    end
    // The one window is tested first, so it wins where the windows overlap.
    if (pair_fits(p, BIT_MARK, ONE_SPACE)) begin
      one_bit = 1'b1;
    end else if (pair_fits(p, BIT_MARK, ZERO_SPACE)) begin
      one_bit = 1'b0;
    end else begin
      r.status = ST_BIT_ERR;
      clear_frame();
      return 1'b1;
    end
    byte_acc = byte_acc | (8'(one_bit) << bit_pos[2:0]);
    if (bit_pos[2:0] != 3'd7) begin
      bit_pos++;
      return 1'b0;
    end
    idx = bit_pos[7:3];
    if (int'(idx) + 1 < FRAME_BYTES) begin
      sum_acc = sum_acc + byte_acc;
      if (idx == 5'd6) mode_seen = byte_acc;
      else if (idx == 5'd7) temp_seen = byte_acc;
      byte_acc = '0;
      bit_pos++;
      return 1'b0;
    end
    // Last byte carries the checksum of all the bytes before it.
    if (sum_acc == byte_acc) begin
      r.status = ST_OK;
      case (mode_seen)
        BYTE_HEAT: r.mode = MODE_HEAT;
        BYTE_COOL: r.mode = MODE_COOL;
        BYTE_AUTO: r.mode = MODE_AUTO;
        BYTE_DRY:  r.mode = MODE_DRY;
        default:   r.mode = MODE_OFF;
      endcase
      r.mode_byte   = mode_seen;
      r.temp_code   = temp_seen;
      r.temperature = 9'(temp_seen) + 9'(temp_floor);
    end else begin
      r.status = ST_SUM_ERR;
    end
    clear_frame();
    return 1'b1;
  endfunction

  // Pick a duration inside the current window, edges favored.
  function automatic logic [DUR_W-1:0] near(int unsigned nom);
    int unsigned lo, hi;
    window_of(nom, lo, hi);
    case ($urandom_range(7))
      0:       return DUR_W'(lo);
      1:       return DUR_W'(hi);
      default: return DUR_W'($urandom_range(hi, lo));
    endcase
  endfunction

  // Pick a duration outside the current window.
  function automatic logic [DUR_W-1:0] far(int unsigned nom);
    int unsigned lo, hi;
    window_of(nom, lo, hi);
    if (lo > 0 && $urandom_range(1) == 1) return DUR_W'($urandom_range(lo - 1, 0));
    return DUR_W'($urandom_range(65535, hi + 1));
  endfunction

  // Send one beat: random gap first, then hold the payload until accepted.
  // Stall is sampled at the falling edge, where every signal is settled.
  task automatic send_pair(logic [DUR_W-1:0] mark, logic [DUR_W-1:0] space);
    in_beat_t  p;
    out_beat_t r;
    bit        took;
    bit        was_open;
    p.mark_us  = mark;
    p.space_us = space;
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= p;
    do begin
      @(negedge clk);
      took = (in_stall === 1'b0);
      @(posedge clk);
    end while (!took);
    was_open = frame_open;
    if (decode_pair(p, r)) begin
      frame_reports.push_back(r);
      results_due++;
    end
    if (was_open || frame_open) live_items++;
  endtask

  // Drop valid and wait until the block has nothing left in flight.
  task automatic settle();
    in_valid <= 1'b0;
    while (frame_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both registers back to back; call only on an idle block.
  task automatic load_config(logic [TOL_W-1:0] tol, logic [TMIN_W-1:0] tmin);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_TOLERANCE;
    cfg_wdata <= tol;
    @(posedge clk);
    cfg_index <= CFG_TEMP_MIN;
    cfg_wdata <= TOL_W'(tmin);
    @(posedge clk);
    cfg_we     <= 1'b0;
    tol_pct    = tol;
    temp_floor = tmin;
  endtask

  // Header plus a full frame of bit pairs, LSB first. A broken frame stops
  // at a random bit with a corrupted pair in its place.
  task automatic send_frame(frame_kind_t kind);
    logic [7:0] body [FRAME_BYTES];
    logic [7:0] sum;
    int         break_at;
    logic       b;
    sum = '0;
    for (int i = 0; i < FRAME_BYTES; i++) body[i] = 8'($urandom);
    case ($urandom_range(5))
      0:       body[6] = BYTE_HEAT;
      1:       body[6] = BYTE_COOL;
      2:       body[6] = BYTE_AUTO;
      3:       body[6] = BYTE_DRY;
      default: ;
    endcase
    for (int i = 0; i < FRAME_BYTES - 1; i++) sum = sum + body[i];
    body[FRAME_BYTES-1] = sum;
    if (kind == FRAME_BAD_SUM) body[FRAME_BYTES-1] = sum ^ 8'($urandom_range(255, 1));
    break_at = -1;
    if (kind == FRAME_BROKEN)
      break_at = ($urandom_range(1) == 1) ? $urandom_range(15) : $urandom_range(FRAME_BITS - 1);
    send_pair(near(HDR_MARK), near(HDR_SPACE));
    for (int k = 0; k < FRAME_BITS; k++) begin
      b = body[k / 8][k % 8];
      if (k == break_at) begin
        case ($urandom_range(3))
          0: send_pair(far(BIT_MARK), near(b ? ONE_SPACE : ZERO_SPACE));
          1: send_pair(near(BIT_MARK), far(b ? ONE_SPACE : ZERO_SPACE));
          2: send_pair(near(HDR_MARK), near(HDR_SPACE));
          default: send_pair(DUR_W'($urandom), DUR_W'($urandom));
        endcase
        return;
      end
      send_pair(near(BIT_MARK), near(b ? ONE_SPACE : ZERO_SPACE));
    end
  endtask

  // A few raw pairs, sometimes with a header-like mark to tease the hunt.
  task automatic noise_burst();
    repeat ($urandom_range(6, 1)) begin
      if ($urandom_range(3) == 0) send_pair(near(HDR_MARK), DUR_W'($urandom));
      else send_pair(DUR_W'($urandom), DUR_W'($urandom));
    end
  endtask

  // Field extremes and near-misses while hunting: none may give a result.
  task automatic test_idle_extremes();
    int unsigned mlo, mhi, slo, shi;
    window_of(HDR_MARK, mlo, mhi);
    window_of(HDR_SPACE, slo, shi);
    send_pair('0, '0);
    send_pair('1, '1);
    send_pair('0, '1);
    send_pair('1, '0);
    send_pair(DUR_W'(BIT_MARK), DUR_W'(ONE_SPACE));
    send_pair(DUR_W'(mlo - 1), DUR_W'(HDR_SPACE));
    send_pair(DUR_W'(HDR_MARK), DUR_W'(shi + 1));
  endtask

  // Open frames with nominal and edge headers, then break them at once,
  // one of them with a second header.
  task automatic test_bit_errors();
    int unsigned mlo, mhi, slo, shi;
    window_of(HDR_MARK, mlo, mhi);
    window_of(HDR_SPACE, slo, shi);
    send_pair(DUR_W'(HDR_MARK), DUR_W'(HDR_SPACE));
    send_pair('1, '1);
    send_pair(DUR_W'(mlo), DUR_W'(slo));
    send_pair(DUR_W'(HDR_MARK), DUR_W'(HDR_SPACE));
    send_pair(DUR_W'(mhi), DUR_W'(shi));
    send_pair('0, '0);
  endtask

  // Bit pairs right on the window edges, then one just past the mark window.
  task automatic test_window_edges();
    int unsigned mlo, mhi, olo, ohi, zlo, zhi;
    window_of(BIT_MARK, mlo, mhi);
    window_of(ONE_SPACE, olo, ohi);
    window_of(ZERO_SPACE, zlo, zhi);
    send_pair(DUR_W'(HDR_MARK), DUR_W'(HDR_SPACE));
    send_pair(DUR_W'(mlo), DUR_W'(ohi));
    send_pair(DUR_W'(mhi), DUR_W'(zlo));
    send_pair(DUR_W'(mlo), DUR_W'(zhi));
    send_pair(DUR_W'(mhi + 1), DUR_W'(ONE_SPACE));
  endtask

  // Full tolerance: the windows overlap and reach down to zero.
  task automatic test_window_overlap();
    load_config(TOL_W'(TOL_MAX), temp_floor);
    send_pair(DUR_W'(HDR_MARK), DUR_W'(HDR_SPACE));
    send_pair(DUR_W'(BIT_MARK), DUR_W'(ZERO_SPACE));
    send_pair('0, '0);
    send_pair('1, '0);
  endtask

  // Random frames, broken frames and noise under one register setting.
  task automatic test_random_frames(logic [TOL_W-1:0] tol, logic [TMIN_W-1:0] tmin,
                                    int unsigned gap_pct, int unsigned stall_pct);
    int unsigned items0, results0;
    load_config(tol, tmin);
    send_gap_pct   = gap_pct;
    recv_stall_pct = stall_pct;
    items0   = live_items;
    results0 = results_due;
    while (live_items - items0 < 250 || results_due - results0 < 6) begin
      case ($urandom_range(9))
        0, 1, 2:       send_frame(FRAME_GOOD);
        3:             send_frame(FRAME_BAD_SUM);
        4, 5, 6, 7, 8: send_frame(FRAME_BROKEN);
        default:       noise_burst();
      endcase
    end
  endtask

  // Result side: random stall, compare each accepted beat with the oldest
  // expectation. Sample at the falling edge, update stall at the rising one.
  initial begin : result_check
    out_beat_t want;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
        if (frame_reports.size() == 0) begin
          flag_error($sformatf("result beat with nothing pending, status %0d",
                               out_data.status));
        end else begin
          want = frame_reports.pop_front();
          if (out_data.status !== want.status)
            flag_error($sformatf("status got %0d want %0d", out_data.status, want.status));
          if (out_data.mode !== want.mode)
            flag_error($sformatf("mode got %0d want %0d", out_data.mode, want.mode));
          if (out_data.mode_byte !== want.mode_byte)
            flag_error($sformatf("mode_byte got %02h want %02h",
                                 out_data.mode_byte, want.mode_byte));
          if (out_data.temp_code !== want.temp_code)
            flag_error($sformatf("temp_code got %02h want %02h",
                                 out_data.temp_code, want.temp_code));
          if (out_data.temperature !== want.temperature)
            flag_error($sformatf("temperature got %0d want %0d",
                                 out_data.temperature, want.temperature));
        end
      end
      @(posedge clk);
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #8_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_we     = 1'b0;
    cfg_index  = CFG_TOLERANCE;
    cfg_wdata  = '0;
    // Mirror the reset state of the block.
    tol_pct    = 7'd25;
    temp_floor = 6'd16;
    mode_seen  = '0;
    temp_seen  = '0;
    clear_frame();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed checks run on reset register values, the last one at full tolerance.
    test_idle_extremes();
    test_bit_errors();
    test_window_edges();
    test_window_overlap();

    // Sender light, receiver heavy; then swapped; then full rate.
    test_random_frames(7'd25, 6'd16, 19, 45);
    test_random_frames(7'd0, 6'd0, 19, 45);
    test_random_frames(7'd100, 6'd63, 45, 19);
    test_random_frames(7'd127, 6'd40, 45, 19);
    test_random_frames(7'd12, 6'd5, 0, 0);
    test_random_frames(7'd60, 6'd63, 0, 0);

    settle();
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/ir_ac_pkg.sv
hw/rtl/ir_ac_in_reg.sv
hw/rtl/ir_ac_win.sv
hw/rtl/ir_ac_core.sv
hw/rtl/ir_ac_frame_decoder.sv
hw/rtl/ir_ac_chk.sv
tb/tb_ir_ac_frame_decoder.sv
